[design/cp932_to_utf8_decoder_assert.svh]
// Assertion helpers for the CP932 decoder.
`ifndef CP932_TO_UTF8_DECODER_ASSERT_SVH
`define CP932_TO_UTF8_DECODER_ASSERT_SVH

// Condition holds at every edge out of reset.
`define C2U_ASSERT_ALWAYS(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) \
    else $error("c2u: invariant violated");

// Same-cycle implication.
`define C2U_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("c2u: implication violated");

// Next-cycle implication.
`define C2U_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("c2u: next-cycle implication violated");

`endif

[design/c2u_pkg.sv]
`default_nettype none
package c2u_pkg;

  localparam logic FUNC_DECODE = 1'b0;
  localparam logic FUNC_WRITE  = 1'b1;

  localparam logic [15:0] DEFAULT_CHAR_RST = 16'h30FB;
  localparam logic [15:0] KANA_BASE        = 16'hFF61;
  localparam logic [7:0]  KANA_FIRST       = 8'hA1;
  localparam logic [7:0]  KANA_LAST        = 8'hDF;
  localparam logic [15:0] PUA_A0           = 16'hF8F0;
  localparam logic [15:0] PUA_FD           = 16'hF8F1;
  localparam logic [15:0] PUA_FE           = 16'hF8F2;
  localparam logic [15:0] PUA_FF           = 16'hF8F3;
  localparam logic [7:0]  TRAIL_FIRST      = 8'h40;
  localparam logic [7:0]  TRAIL_LAST       = 8'hFC;
  localparam logic [7:0]  TRAIL_SPAN       = 8'd189;
  localparam logic [5:0]  SECOND_ROW_BASE  = 6'd31;

  localparam logic [7:0]  UTF8_LEAD2       = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3       = 8'hE0;
  localparam logic [7:0]  UTF8_CONT        = 8'h80;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QLVL_W      = 3;

  typedef struct packed {
    logic [15:0] cp;
    logic        extra_nul;  // a NUL byte follows the code point
  } c2u_entry_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
  endfunction

endpackage
`default_nettype wire

[design/c2u_ram.sv]
`default_nettype none
module c2u_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 11340,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/c2u_front.sv]
`default_nettype none
module c2u_front #(
  parameter int TABLE_ENTRIES = 11340
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [39:0]                s_axis_tdata,
  input  wire logic                       s_axis_tlast,
  input  wire logic                       s_axis_tuser,
  input  wire logic                       cfg_we,
  input  wire logic [15:0]                cfg_wdata,
  input  wire logic [c2u_pkg::QLVL_W-1:0] q_level,
  output logic                            push_valid,
  output c2u_pkg::c2u_entry_t             push_entry
);
  import c2u_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [14:0] ENTRIES_LIM = 15'(TABLE_ENTRIES);

  logic [7:0]  in_byte;
  logic [13:0] table_index;
  logic [15:0] table_value;
  logic        accept;

  logic [15:0] default_char;
  logic        lead_pending;
  logic [7:0]  lead_byte;

  logic        s1_valid;
  logic        s1_lookup;
  logic [15:0] s1_cp;
  logic        s1_extra;

  logic        emit;
  logic        lookup;
  logic [15:0] cp;
  logic        extra;
  logic        lead_pending_next;
  logic [7:0]  lead_byte_next;

  logic [5:0]  row;
  logic [13:0] rd_index;
  logic        ram_we;
  logic [15:0] ram_rdata;

  assign in_byte     = s_axis_tdata[7:0];
  assign table_index = s_axis_tdata[21:8];
  assign table_value = s_axis_tdata[37:22];

  // room for the item in flight plus a new one
  assign s_axis_tready = (q_level + QLVL_W'(s1_valid)) < QLVL_W'(QUEUE_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign row = (lead_byte <= 8'h9F) ? 6'(lead_byte - 8'h81)
                                    : 6'(lead_byte - 8'hE0) + SECOND_ROW_BASE;
  assign rd_index = 14'(row) * 14'(TRAIL_SPAN) + {6'b0, in_byte - TRAIL_FIRST};

  assign ram_we = accept && (s_axis_tuser == FUNC_WRITE)
                  && ({1'b0, table_index} < ENTRIES_LIM);

  c2u_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_ENTRIES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (table_index[AW-1:0]),
    .wdata (table_value),
    .raddr (rd_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    emit              = 1'b0;
    lookup            = 1'b0;
    cp                = default_char;
    extra             = 1'b0;
    lead_pending_next = lead_pending;
    lead_byte_next    = lead_byte;
    if (accept && s_axis_tuser == FUNC_DECODE) begin
      emit = 1'b1;
      if (lead_pending) begin
        lead_pending_next = 1'b0;
        if (in_byte == 8'h00) begin
          extra = 1'b1;
        end else if (in_byte >= TRAIL_FIRST && in_byte <= TRAIL_LAST) begin
          lookup = 1'b1;
        end
      end else if (is_lead(in_byte)) begin
        if (!s_axis_tlast) begin
          emit              = 1'b0;
          lead_pending_next = 1'b1;
          lead_byte_next    = in_byte;
        end
      end else if (in_byte < 8'h80) begin
        cp = {8'h00, in_byte};
      end else if (in_byte >= KANA_FIRST && in_byte <= KANA_LAST) begin
        cp = KANA_BASE + {8'h00, in_byte - KANA_FIRST};
      end else begin
        case (in_byte)
          8'h80:   cp = 16'h0080;
          8'hA0:   cp = PUA_A0;
          8'hFD:   cp = PUA_FD;
          8'hFE:   cp = PUA_FE;
          8'hFF:   cp = PUA_FF;
          default: cp = default_char;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_char <= DEFAULT_CHAR_RST;
      lead_pending <= 1'b0;
      lead_byte    <= 8'h00;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_char <= cfg_wdata;
      end
      lead_pending <= lead_pending_next;
      lead_byte    <= lead_byte_next;
      s1_valid     <= emit;
    end
  end

  always_ff @(posedge clk) begin
    s1_lookup <= lookup;
    s1_cp     <= cp;
    s1_extra  <= extra;
  end

  // table read lands here; zero entry means unmapped
  assign push_valid           = s1_valid;
  assign push_entry.cp        = !s1_lookup ? s1_cp
                              : (ram_rdata != 16'h0000) ? ram_rdata : default_char;
  assign push_entry.extra_nul = s1_extra;

endmodule
`default_nettype wire

[design/c2u_queue.sv]
`default_nettype none
module c2u_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire c2u_pkg::c2u_entry_t        push_entry,
  input  wire logic                       pop,
  output logic                            q_valid,
  output c2u_pkg::c2u_entry_t             head,
  output logic      [c2u_pkg::QLVL_W-1:0] level
);
  import c2u_pkg::*;

  c2u_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;

  assign q_valid = (level != '0);
  assign head    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      level <= level + QLVL_W'(push) - QLVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

[design/c2u_back.sv]
`default_nettype none
module c2u_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire c2u_pkg::c2u_entry_t head,
  output logic                     pop,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [7:0]               m_axis_tdata,
  output logic                     m_axis_tlast
);
  import c2u_pkg::*;

  logic [1:0] pos;
  logic [1:0] nbytes;
  logic [2:0] total;
  logic [7:0] byte_val;
  logic       is_last;
  logic       load;

  always_comb begin
    if (head.cp[15:7] == '0) begin
      nbytes = 2'd1;
    end else if (head.cp[15:11] == '0) begin
      nbytes = 2'd2;
    end else begin
      nbytes = 2'd3;
    end
  end

  assign total   = {1'b0, nbytes} + {2'b00, head.extra_nul};
  assign is_last = ({1'b0, pos} == total - 3'd1);

  always_comb begin
    if (pos == nbytes) begin
      byte_val = 8'h00;
    end else begin
      case ({nbytes, pos})
        4'b01_00: byte_val = head.cp[7:0];
        4'b10_00: byte_val = UTF8_LEAD2 | {3'b000, head.cp[10:6]};
        4'b10_01: byte_val = UTF8_CONT  | {2'b00, head.cp[5:0]};
        4'b11_00: byte_val = UTF8_LEAD3 | {4'h0, head.cp[15:12]};
        4'b11_01: byte_val = UTF8_CONT  | {2'b00, head.cp[11:6]};
        default:  byte_val = UTF8_CONT  | {2'b00, head.cp[5:0]};
      endcase
    end
  end

  assign load = q_valid && (!m_axis_tvalid || m_axis_tready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= 2'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load) begin
        pos           <= is_last ? 2'd0 : pos + 2'd1;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= byte_val;
      m_axis_tlast <= is_last;
    end
  end

endmodule
`default_nettype wire

[design/cp932_to_utf8_decoder.sv]
// CP932 (Shift-JIS) to UTF-8 decoder.
// Input stream s_axis: one item per byte. tuser selects decode (0) or map
// table write (1); tlast marks the last text byte. Table writes load the
// double-byte map RAM and must precede decoding of the entries they fill.
// Output stream m_axis: UTF-8 bytes, tlast on the final byte of each input item.
// Config: cfg_we/cfg_wdata set the replacement code point (reset 0x30FB).
// Each decoded item is registered in the front stage, written into the queue, then loaded into the output register.
// Throughput: one output byte per cycle while m_axis_tready is high; a decode item
// gives 1 to 4 output bytes; a lead byte held for its trail and a table write produce
// nothing at the output. The map RAM has one read and one write port, one access per item.
// A four-entry queue separates classification from the UTF-8 encoder; when the
// receiver stalls the output register holds and the queue fills, after which
// s_axis_tready drops. Reset clears the pending lead, the queue and the output;
// the map RAM is not cleared and needs no clearing pass.
`default_nettype none
`include "cp932_to_utf8_decoder_assert.svh"
module cp932_to_utf8_decoder #(
  parameter int TABLE_ENTRIES = 11340
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // in_byte[7:0], table_index[21:8], table_value[37:22]
  input  wire logic        s_axis_tlast,  // end_of_text
  input  wire logic        s_axis_tuser,  // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte[7:0]
  output logic             m_axis_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import c2u_pkg::*;

  logic              push_valid;
  c2u_entry_t        push_entry;
  logic              pop;
  logic              q_valid;
  c2u_entry_t        head;
  logic [QLVL_W-1:0] q_level;
  logic              write_accept;

  assign write_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_WRITE);

  c2u_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_level       (q_level),
    .push_valid    (push_valid),
    .push_entry    (push_entry)
  );

  c2u_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head),
    .level      (q_level)
  );

  c2u_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `C2U_ASSERT_ALWAYS(a_level_bound, clk, rst, q_level <= QLVL_W'(QUEUE_DEPTH))
  `C2U_ASSERT_IMPL(a_push_room, clk, rst, push_valid, q_level < QLVL_W'(QUEUE_DEPTH))
  `C2U_ASSERT_NEXT(a_write_silent, clk, rst, write_accept, !push_valid)
  `C2U_ASSERT_IMPL(a_pop_needs_data, clk, rst, pop, q_valid)

endmodule
`default_nettype wire

[verif/cp932_to_utf8_decoder_test.sv]
module cp932_to_utf8_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import c2u_pkg::*;

  localparam int MAP_ENTRIES   = 11340;
  localparam int RANDOM_ITEMS  = 70;
  localparam int PHASES        = 7;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  class utf8_stream_scoreboard;
    logic [15:0] replacement;
    bit          lead_held;
    logic [7:0]  held_lead;
    bit   [15:0] code_map [MAP_ENTRIES];
    bit          mapped [MAP_ENTRIES];
    logic [7:0]  item_bytes [$];
    utf8_beat_t  due_utf8 [$];
    int          errors;

    function new();
      replacement = DEFAULT_CHAR_RST;
      lead_held   = 1'b0;
      held_lead   = 8'h00;
      errors      = 0;
    endfunction

    function bit double_lead(logic [7:0] b);
      return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
    endfunction

    function int map_slot(logic [7:0] lead, logic [7:0] trail);
      int row;
      if (lead <= 8'h9F) row = int'(lead) - 'h81;
      else row = int'(SECOND_ROW_BASE) + int'(lead) - 'hE0;
      return row * int'(TRAIL_SPAN) + int'(trail) - int'(TRAIL_FIRST);
    endfunction

    function logic [15:0] single_code(logic [7:0] b);
      if (b < 8'h80) return {8'h00, b};
      if (b >= KANA_FIRST && b <= KANA_LAST) return KANA_BASE + {8'h00, b - KANA_FIRST};
      case (b)
        8'h80: return 16'h0080;
        8'hA0: return PUA_A0;
        8'hFD: return PUA_FD;
        8'hFE: return PUA_FE;
        8'hFF: return PUA_FF;
        default: return replacement;
      endcase
    endfunction

    // encoding by magnitude only, surrogates included
    function void add_code(logic [15:0] cp);
      if (cp < 16'h0080) begin
        item_bytes.push_back(cp[7:0]);
      end else if (cp < 16'h0800) begin
        item_bytes.push_back(UTF8_LEAD2 | {3'b000, cp[10:6]});
        item_bytes.push_back(UTF8_CONT | {2'b00, cp[5:0]});
      end else begin
        item_bytes.push_back(UTF8_LEAD3 | {4'h0, cp[15:12]});
        item_bytes.push_back(UTF8_CONT | {2'b00, cp[11:6]});
        item_bytes.push_back(UTF8_CONT | {2'b00, cp[5:0]});
      end
    endfunction

    function void predict_utf8(logic op, logic [7:0] b, logic eot, logic [13:0] slot,
                               logic [15:0] code);
      logic [15:0] cp;
      utf8_beat_t  beat;
      item_bytes.delete();
      if (op == FUNC_WRITE) begin
        if (slot < MAP_ENTRIES) begin
          code_map[slot] = code;
          mapped[slot]   = 1'b1;
        end
        return;
      end
      if (lead_held) begin
        lead_held = 1'b0;
        if (b == 8'h00) begin
          // NUL trail: replacement, then the NUL on its own
          add_code(replacement);
          add_code(16'h0000);
        end else begin
          cp = 16'h0000;
          if (b >= TRAIL_FIRST && b <= TRAIL_LAST) cp = code_map[map_slot(held_lead, b)];
          add_code(cp != 16'h0000 ? cp : replacement);
        end
      end else if (double_lead(b)) begin
        if (eot) begin
          add_code(replacement);
        end else begin
          lead_held = 1'b1;
          held_lead = b;
        end
      end else begin
        add_code(single_code(b));
      end
      foreach (item_bytes[k]) begin
        beat.data = item_bytes[k];
        beat.last = (k == item_bytes.size() - 1);
        due_utf8.push_back(beat);
      end
    endfunction

    task check_utf8(logic [7:0] data, logic last);
      utf8_beat_t want;
      if (due_utf8.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", data, last));
        return;
      end
      want = due_utf8.pop_front();
      if (data !== want.data) report($sformatf("byte %02h, want %02h", data, want.data));
      if (last !== want.last) report($sformatf("last %0b, want %0b (byte %02h)",
                                              last, want.last, want.data));
    endtask

    task report(string msg);
      errors++;
      // keep the log short on a badly broken build
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we        = 1'b0;
  logic [15:0] cfg_wdata     = '0;

  utf8_stream_scoreboard utf8_sb = new();
  int unsigned cycle_count = 0;
  logic [31:0] ready_tick  = '0;
  int          burst_left  = 0;
  int          loaded_slots [$];

  cp932_to_utf8_decoder #(
    .TABLE_ENTRIES(MAP_ENTRIES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) utf8_sb.check_utf8(m_axis_tdata, m_axis_tlast);
  end

  // receiver: free-flowing, coin-toss, mostly stalled, then alternating on and off
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    case ((ready_tick / 97) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ready_tick[3];
    endcase
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("cp932_to_utf8_decoder_test: done, errors");
    $finish;
  end

  task automatic send_item(logic op, logic [7:0] b, logic eot, logic [13:0] slot,
                           logic [15:0] code);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= eot;
    s_axis_tdata  <= {2'b00, code, slot, b};
    do @(posedge clk); while (!s_axis_tready);
    utf8_sb.predict_utf8(op, b, eot, slot, code);
  endtask

  // a trail that would hit a never-loaded entry is swapped for one outside the trail range
  task automatic send_text(logic [7:0] b, logic eot);
    logic [7:0] text;
    text = b;
    if (utf8_sb.lead_held && b >= TRAIL_FIRST && b <= TRAIL_LAST &&
        !utf8_sb.mapped[utf8_sb.map_slot(utf8_sb.held_lead, b)])
      text = $urandom_range(0, 1) ? 8'($urandom_range(0, 'h3F)) : 8'($urandom_range('hFD, 'hFF));
    send_item(FUNC_DECODE, text, eot, 14'($urandom), 16'($urandom));
  endtask

  task automatic load_entry(int slot, logic [15:0] code);
    send_item(FUNC_WRITE, 8'($urandom), 1'($urandom), 14'(slot), code);
    if (slot < MAP_ENTRIES) loaded_slots.push_back(slot);
  endtask

  task automatic send_pair(int slot, logic eot);
    int         row;
    logic [7:0] lead;
    row = slot / int'(TRAIL_SPAN);
    if (row < int'(SECOND_ROW_BASE)) lead = 8'('h81 + row);
    else lead = 8'('hE0 + row - int'(SECOND_ROW_BASE));
    send_text(lead, 1'b0);
    send_text(8'(int'(TRAIL_FIRST) + slot % int'(TRAIL_SPAN)), eot);
  endtask

  function automatic logic [15:0] random_code();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1, 2: return 16'($urandom_range(1, 'h7F));
      3, 4: return 16'($urandom_range('h80, 'h7FF));
      default: return 16'($urandom_range('h800, 'hFFFF));
    endcase
  endfunction

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (utf8_sb.due_utf8.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_replacement(logic [15:0] code);
    cfg_wdata <= code;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    utf8_sb.replacement = code;
  endtask

  initial begin
    int item_count;
    int pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // corners of both lead ranges, then writes past the end of the table
    load_entry(0, 16'h0000);
    load_entry(5858, 16'h0041);
    load_entry(5859, 16'h07FF);
    load_entry(11339, 16'hFFFF);
    load_entry(100, 16'hD800);
    load_entry(MAP_ENTRIES, 16'h1234);
    load_entry(16383, 16'hBEEF);
    repeat (40) load_entry($urandom_range(0, MAP_ENTRIES - 1), random_code());

    send_text(8'h00, 1'b0);
    send_text(8'h7F, 1'b1);
    send_text(8'h80, 1'b0);
    send_text(8'hA0, 1'b0);
    send_text(8'hA1, 1'b1);
    send_text(8'hDF, 1'b0);
    send_text(8'hFD, 1'b0);
    send_text(8'hFE, 1'b1);
    send_text(8'hFF, 1'b0);
    send_pair(0, 1'b0);
    send_pair(5858, 1'b0);
    send_pair(5859, 1'b1);
    send_pair(100, 1'b0);
    // table write between lead and trail must leave the lead held
    send_text(8'hFC, 1'b0);
    load_entry(50, 16'h00E9);
    send_text(8'hFC, 1'b0);
    send_text(8'h81, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'h88, 1'b0);
    send_text(8'h3F, 1'b1);
    send_text(8'hE5, 1'b0);
    send_text(8'hFD, 1'b0);
    send_text(8'h90, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: set_replacement(16'h0000);
        1: set_replacement(16'hFFFF);
        2: set_replacement(16'h007F);
        3: set_replacement(16'h0080);
        4: set_replacement(16'h07FF);
        5: set_replacement(16'h0800);
        default: set_replacement(16'($urandom));
      endcase
      item_count = 0;
      while (item_count < RANDOM_ITEMS / PHASES + 1) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          send_pair(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)],
                    ($urandom_range(0, 7) == 0));
          item_count += 2;
        end else if (pick < 62) begin
          load_entry($urandom_range(0, MAP_ENTRIES - 1), random_code());
          item_count++;
        end else if (pick < 65) begin
          // out of range, dropped by the block
          load_entry($urandom_range(MAP_ENTRIES, 16383), random_code());
        end else if (pick < 70) begin
          send_text($urandom_range(0, 1) ? 8'($urandom_range('h81, 'h9F))
                                         : 8'($urandom_range('hE0, 'hFC)), 1'b1);
          item_count++;
        end else begin
          send_text(8'($urandom), ($urandom_range(0, 7) == 0));
          item_count++;
        end
      end
    end

    settle();
    if (utf8_sb.errors == 0) $display("cp932_to_utf8_decoder_test: done, clean");
    else $display("cp932_to_utf8_decoder_test: done, errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/c2u_pkg.sv
design/c2u_ram.sv
design/c2u_front.sv
design/c2u_queue.sv
design/c2u_back.sv
design/cp932_to_utf8_decoder.sv
verif/cp932_to_utf8_decoder_test.sv
